// ===== sv/set_algebra_engine_defines.svh =====
// Assertion macros shared by the set algebra engine RTL.
`ifndef SET_ALGEBRA_ENGINE_DEFINES_SVH
`define SET_ALGEBRA_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SAE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("set algebra engine: implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SAE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("set algebra engine: next-cycle check failed");

`endif

// ===== sv/sae_pkg.sv =====
package sae_pkg;

  localparam int SET_CAPACITY = 32;
  localparam int STORE_DEPTH  = 32;
  localparam int IDX_W        = $clog2(STORE_DEPTH);
  localparam int CNT_W        = 6;
  localparam int ELEM_W       = 32;

  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 40;

  // Result word bit positions above the element.
  localparam int RES_VALID_BIT = 32;
  localparam int RES_ASB_BIT   = 33;
  localparam int RES_BSA_BIT   = 34;
  localparam int RES_EQ_BIT    = 35;
  localparam int RES_OVF_BIT   = 36;
  localparam int HAS_ELEM_BIT  = 32;

  localparam logic [1:0] MODE_UNION = 2'd0;
  localparam logic [1:0] MODE_INTER = 2'd1;
  localparam logic [1:0] MODE_DIFF  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_CMP,
    ST_LD_INS,
    ST_LD_END,
    ST_CP_START,
    ST_CP_CHECK,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_IN_RD,
    ST_IN_CMP,
    ST_OUT_NEXT,
    ST_FLAGS,
    ST_EM_SCAN,
    ST_EM_OUT,
    ST_EM_EMPTY
  } state_t;

endpackage

// ===== sv/set_algebra_engine.sv =====
// Channel  Direction  Handshake             Payload
// s_*      in         s_tvalid / s_tready   tdata: element, has_element; tuser: set_select;
//                                           tlast: last_of_set
// m_*      out        m_tvalid / m_tready   tdata: result word; tlast: last_result
// cfg_*    in         cfg_valid / cfg_ready cfg_data: op_mode
//
// A loaded element is checked against the stored entries by the duplicate compare, which
// reads one store entry at a time and tests it through the single comparator.
// The final item of B starts two passes over the stores, then a flag state and an emit
// sweep over up to 64 slots. The input is not ready while an item or a run is in
// progress; the output register lets the next item enter while the final result waits.
// rst is synchronous and active high; store contents are not cleared.
`include "set_algebra_engine_defines.svh"

module set_algebra_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [31:0] element, [32] has_element, [39:33] zero
  input  logic [sae_pkg::IN_DATA_W-1:0]  s_tdata,
  // [0] set_select
  input  logic [0:0]                     s_tuser,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [31:0] result_element, [32] result_valid, [33] a_subset_of_b,
  // [34] b_subset_of_a, [35] sets_equal, [36] overflow, [39:37] zero
  output logic [sae_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_data
);
  import sae_pkg::*;

  state_t state, state_next;

  logic [ELEM_W-1:0] store_a [STORE_DEPTH];
  logic [ELEM_W-1:0] store_b [STORE_DEPTH];
  logic [ELEM_W-1:0] rdata_a, rdata_b;
  logic [IDX_W-1:0]  addr_a, addr_b;
  logic              wr_a, wr_b;

  logic [1:0]        op_mode;
  logic [CNT_W-1:0]  count_a, count_a_next, count_b, count_b_next;
  logic              loading_b, loading_b_next;
  logic              overflow_seen, overflow_seen_next;
  logic [ELEM_W-1:0] key, key_next;
  logic              item_has, item_has_next, item_last, item_last_next;
  logic [IDX_W-1:0]  i, i_next, j, j_next, k, k_next;
  logic              pass, pass_next, list, list_next;
  logic [STORE_DEPTH-1:0] hit_a, hit_a_next, hit_b, hit_b_next;
  logic [STORE_DEPTH-1:0] sel_a, sel_a_next, sel_b, sel_b_next;
  logic              asb, asb_next, bsa, bsa_next, eq, eq_next;

  logic                  out_load, out_last_next;
  logic [OUT_DATA_W-1:0] out_data_next;

  logic [CNT_W-1:0]  cnt_cur, count_x, count_y;
  logic [ELEM_W-1:0] rdata_t, rdata_x, rdata_y, rdata_l;
  logic [STORE_DEPTH-1:0] mask_a, mask_b, above;
  logic              out_free, later, cur_sel;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  assign cnt_cur = loading_b ? count_b : count_a;
  assign count_x = pass ? count_b : count_a;
  assign count_y = pass ? count_a : count_b;
  assign rdata_t = loading_b ? rdata_b : rdata_a;
  assign rdata_x = pass ? rdata_b : rdata_a;
  assign rdata_y = pass ? rdata_a : rdata_b;
  assign rdata_l = list ? rdata_b : rdata_a;

  always_comb begin
    for (int b = 0; b < STORE_DEPTH; b++) begin
      mask_a[b] = CNT_W'(b) < count_a;
      mask_b[b] = CNT_W'(b) < count_b;
      above[b]  = IDX_W'(b) > k;
    end
  end

  assign cur_sel = list ? sel_b[k] : sel_a[k];
  // Another selected slot follows the current one in emit order.
  assign later = list ? |(sel_b & above) : (|(sel_a & above) || |sel_b);

  always_comb begin
    unique case (state)
      ST_CP_CHECK, ST_OUT_RD, ST_OUT_LD, ST_IN_RD, ST_IN_CMP, ST_OUT_NEXT: begin
        addr_a = pass ? j : i;
        addr_b = pass ? i : j;
      end
      ST_FLAGS, ST_EM_SCAN, ST_EM_OUT, ST_EM_EMPTY: begin
        addr_a = k;
        addr_b = k;
      end
      default: begin
        addr_a = j;
        addr_b = j;
      end
    endcase
  end

  always_comb begin
    state_next         = state;
    count_a_next       = count_a;
    count_b_next       = count_b;
    loading_b_next     = loading_b;
    overflow_seen_next = overflow_seen;
    key_next           = key;
    item_has_next      = item_has;
    item_last_next     = item_last;
    i_next             = i;
    j_next             = j;
    k_next             = k;
    pass_next          = pass;
    list_next          = list;
    hit_a_next         = hit_a;
    hit_b_next         = hit_b;
    sel_a_next         = sel_a;
    sel_b_next         = sel_b;
    asb_next           = asb;
    bsa_next           = bsa;
    eq_next            = eq;
    wr_a               = 1'b0;
    wr_b               = 1'b0;
    out_load           = 1'b0;
    out_last_next      = 1'b0;
    out_data_next      = '0;
    out_data_next[RES_ASB_BIT] = asb;
    out_data_next[RES_BSA_BIT] = bsa;
    out_data_next[RES_EQ_BIT]  = eq;
    out_data_next[RES_OVF_BIT] = overflow_seen;

    unique case (state)
      ST_IDLE: begin
        // Items for the other set than the one loading are dropped whole.
        if (s_tvalid && (s_tuser[0] == loading_b)) begin
          key_next       = s_tdata[ELEM_W-1:0];
          item_has_next  = s_tdata[HAS_ELEM_BIT];
          item_last_next = s_tlast;
          j_next         = '0;
          if (!s_tdata[HAS_ELEM_BIT]) begin
            state_next = ST_LD_END;
          end else if (cnt_cur == '0) begin
            state_next = ST_LD_INS;
          end else begin
            state_next = ST_LD_RD;
          end
        end
      end
      ST_LD_RD: begin
        state_next = ST_LD_CMP;
      end
      ST_LD_CMP: begin
        if (rdata_t == key) begin
          state_next = ST_LD_END;
        end else if ((CNT_W'(j) + CNT_W'(1)) < cnt_cur) begin
          j_next     = j + IDX_W'(1);
          state_next = ST_LD_RD;
        end else begin
          state_next = ST_LD_INS;
        end
      end
      ST_LD_INS: begin
        if (cnt_cur >= CNT_W'(SET_CAPACITY)) begin
          overflow_seen_next = 1'b1;
        end else if (loading_b) begin
          wr_b         = 1'b1;
          count_b_next = count_b + CNT_W'(1);
        end else begin
          wr_a         = 1'b1;
          count_a_next = count_a + CNT_W'(1);
        end
        state_next = ST_LD_END;
      end
      ST_LD_END: begin
        if (!item_last) begin
          state_next = ST_IDLE;
        end else if (!loading_b) begin
          loading_b_next = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          state_next = ST_CP_START;
        end
      end
      ST_CP_START: begin
        hit_a_next = '0;
        hit_b_next = '0;
        pass_next  = 1'b0;
        i_next     = '0;
        state_next = ST_CP_CHECK;
      end
      ST_CP_CHECK: begin
        if (count_x != '0) begin
          state_next = ST_OUT_RD;
        end else if (!pass) begin
          pass_next = 1'b1;
        end else begin
          state_next = ST_FLAGS;
        end
      end
      ST_OUT_RD: begin
        state_next = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        key_next   = rdata_x;
        j_next     = '0;
        state_next = (count_y == '0) ? ST_OUT_NEXT : ST_IN_RD;
      end
      ST_IN_RD: begin
        state_next = ST_IN_CMP;
      end
      ST_IN_CMP: begin
        if (rdata_y == key) begin
          if (pass) begin
            hit_b_next[i] = 1'b1;
          end else begin
            hit_a_next[i] = 1'b1;
          end
          state_next = ST_OUT_NEXT;
        end else if ((CNT_W'(j) + CNT_W'(1)) < count_y) begin
          j_next     = j + IDX_W'(1);
          state_next = ST_IN_RD;
        end else begin
          state_next = ST_OUT_NEXT;
        end
      end
      ST_OUT_NEXT: begin
        if ((CNT_W'(i) + CNT_W'(1)) < count_x) begin
          i_next     = i + IDX_W'(1);
          state_next = ST_OUT_RD;
        end else if (!pass) begin
          pass_next  = 1'b1;
          i_next     = '0;
          state_next = ST_CP_CHECK;
        end else begin
          state_next = ST_FLAGS;
        end
      end
      ST_FLAGS: begin
        asb_next = (count_a <= count_b) && (&(hit_a | ~mask_a));
        bsa_next = (count_b <= count_a) && (&(hit_b | ~mask_b));
        eq_next  = (count_a == count_b) && (count_a <= count_b) && (&(hit_a | ~mask_a));
        unique case (op_mode)
          MODE_UNION: begin
            sel_a_next = mask_a;
            sel_b_next = mask_b & ~hit_b;
          end
          MODE_INTER: begin
            sel_a_next = mask_a & hit_a;
            sel_b_next = '0;
          end
          MODE_DIFF: begin
            sel_a_next = mask_a & ~hit_a;
            sel_b_next = '0;
          end
          default: begin
            sel_a_next = '0;
            sel_b_next = '0;
          end
        endcase
        list_next  = 1'b0;
        k_next     = '0;
        state_next = ((sel_a_next | sel_b_next) == '0) ? ST_EM_EMPTY : ST_EM_SCAN;
      end
      ST_EM_SCAN: begin
        if (cur_sel) begin
          state_next = ST_EM_OUT;
        end else if (k == IDX_W'(STORE_DEPTH - 1)) begin
          k_next    = '0;
          list_next = 1'b1;
          if (list) begin
            state_next = ST_IDLE;
          end
        end else begin
          k_next = k + IDX_W'(1);
        end
      end
      ST_EM_OUT: begin
        if (out_free) begin
          out_load                     = 1'b1;
          out_data_next[ELEM_W-1:0]    = rdata_l;
          out_data_next[RES_VALID_BIT] = 1'b1;
          out_last_next                = !later;
          if (later) begin
            state_next = ST_EM_SCAN;
            if (k == IDX_W'(STORE_DEPTH - 1)) begin
              k_next    = '0;
              list_next = 1'b1;
            end else begin
              k_next = k + IDX_W'(1);
            end
          end else begin
            count_a_next       = '0;
            count_b_next       = '0;
            loading_b_next     = 1'b0;
            overflow_seen_next = 1'b0;
            state_next         = ST_IDLE;
          end
        end
      end
      ST_EM_EMPTY: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_last_next      = 1'b1;
          count_a_next       = '0;
          count_b_next       = '0;
          loading_b_next     = 1'b0;
          overflow_seen_next = 1'b0;
          state_next         = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count_a       <= '0;
      count_b       <= '0;
      loading_b     <= 1'b0;
      overflow_seen <= 1'b0;
      op_mode       <= MODE_UNION;
      m_tvalid      <= 1'b0;
    end else begin
      state         <= state_next;
      count_a       <= count_a_next;
      count_b       <= count_b_next;
      loading_b     <= loading_b_next;
      overflow_seen <= overflow_seen_next;
      if (cfg_valid && cfg_ready) begin
        op_mode <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key       <= key_next;
    item_has  <= item_has_next;
    item_last <= item_last_next;
    i         <= i_next;
    j         <= j_next;
    k         <= k_next;
    pass      <= pass_next;
    list      <= list_next;
    hit_a     <= hit_a_next;
    hit_b     <= hit_b_next;
    sel_a     <= sel_a_next;
    sel_b     <= sel_b_next;
    asb       <= asb_next;
    bsa       <= bsa_next;
    eq        <= eq_next;
    if (out_load) begin
      m_tdata <= out_data_next;
      m_tlast <= out_last_next;
    end
  end

  // Set stores: one write port and one registered read port each.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      store_a[count_a[IDX_W-1:0]] <= key;
    end
    rdata_a <= store_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      store_b[count_b[IDX_W-1:0]] <= key;
    end
    rdata_b <= store_b[addr_b];
  end

  // The has flag only steers the load sequence; it is held for the whole item.
  `SAE_ASSERT_IMP(a_has_load, (state == ST_LD_INS), item_has)
  `SAE_ASSERT_IMP(a_count_cap, 1'b1,
                  (count_a <= CNT_W'(SET_CAPACITY)) && (count_b <= CNT_W'(SET_CAPACITY)))
  `SAE_ASSERT_IMP(a_empty_last, (m_tvalid && !m_tdata[RES_VALID_BIT]), m_tlast)
  `SAE_ASSERT_NEXT(a_run_clear, (out_load && out_last_next),
                   (count_a == '0) && (count_b == '0) && !loading_b && !overflow_seen)
  `SAE_ASSERT_IMP(a_ovf_full, $rose(overflow_seen),
                  (count_a == CNT_W'(SET_CAPACITY)) || (count_b == CNT_W'(SET_CAPACITY)))

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sae_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int HOLD_OFF   = 100;
  localparam int WD_LIMIT   = 20000;
  localparam int RAND_ITEMS = 100;

  typedef struct packed {
    logic        sel;
    logic [31:0] elem;
    logic        has;
    logic        last;
  } set_item_t;

  typedef struct {
    logic [31:0] elem;
    logic        valid;
    logic        asb;
    logic        bsa;
    logic        eq;
    logic        ovf;
    logic        last;
  } set_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_data = '0;

  set_algebra_engine u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Stimulus and bookkeeping.
  set_item_t   pending_items[$];
  set_result_t answer_q[$];
  int          items_left = 0;
  int          items_pushed = 0;
  int          errors = 0;
  int          wd_cycles = 0;
  bit          idle_s = 1'b1;
  bit          idle_m = 1'b1;
  bit          s_acc = 1'b0;
  int          s_gap = 0;
  int          m_stall = 0;

  // Predictor state.
  logic [31:0] a_elems[$];
  logic [31:0] b_elems[$];
  bit          loading_b_m = 1'b0;
  bit          ovf_m = 1'b0;
  logic [1:0]  mode_m = MODE_UNION;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit member(input logic [31:0] q[$], input logic [31:0] v);
    foreach (q[i]) if (q[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit contained(input logic [31:0] x[$], input logic [31:0] y[$]);
    if (x.size() > y.size()) return 1'b0;
    foreach (x[i]) if (!member(y, x[i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void add_expected(logic [31:0] v, bit valid, bit asb, bit bsa, bit eq);
    set_result_t r;
    r.elem  = v;
    r.valid = valid;
    r.asb   = asb;
    r.bsa   = bsa;
    r.eq    = eq;
    r.ovf   = ovf_m;
    r.last  = 1'b0;
    answer_q.push_back(r);
  endfunction

  // Duplicates are dropped silently, even when the store is full.
  function automatic void store_elem(bit to_b, logic [31:0] v);
    if (to_b) begin
      if (member(b_elems, v)) return;
      if (b_elems.size() >= SET_CAPACITY) ovf_m = 1'b1;
      else b_elems.push_back(v);
    end else begin
      if (member(a_elems, v)) return;
      if (a_elems.size() >= SET_CAPACITY) ovf_m = 1'b1;
      else a_elems.push_back(v);
    end
  endfunction

  function automatic void track_set_item(bit sel, logic [31:0] v, bit has, bit last);
    bit asb, bsa, eq;
    int first;
    // An item for the other set is ignored, its last flag included.
    if (sel != loading_b_m) return;
    if (!loading_b_m) begin
      if (has) store_elem(1'b0, v);
      if (last) loading_b_m = 1'b1;
      return;
    end
    if (has) store_elem(1'b1, v);
    if (!last) return;
    asb = contained(a_elems, b_elems);
    bsa = contained(b_elems, a_elems);
    eq  = (a_elems.size() == b_elems.size()) && asb;
    first = answer_q.size();
    case (mode_m)
      MODE_UNION: begin
        foreach (a_elems[i]) add_expected(a_elems[i], 1'b1, asb, bsa, eq);
        foreach (b_elems[i])
          if (!member(a_elems, b_elems[i])) add_expected(b_elems[i], 1'b1, asb, bsa, eq);
      end
      MODE_INTER: begin
        foreach (a_elems[i])
          if (member(b_elems, a_elems[i])) add_expected(a_elems[i], 1'b1, asb, bsa, eq);
      end
      MODE_DIFF: begin
        foreach (a_elems[i])
          if (!member(b_elems, a_elems[i])) add_expected(a_elems[i], 1'b1, asb, bsa, eq);
      end
      default: ;
    endcase
    if (answer_q.size() == first) add_expected('0, 1'b0, asb, bsa, eq);
    answer_q[answer_q.size() - 1].last = 1'b1;
    a_elems.delete();
    b_elems.delete();
    loading_b_m = 1'b0;
    ovf_m = 1'b0;
  endfunction

  task automatic report_mismatch(string what, logic [39:0] exp_v, logic [39:0] got_v);
    errors++;
    $display("%0t MISMATCH %s: expected %h, got %h", $time, what, exp_v, got_v);
  endtask

  task automatic check_result(logic [OUT_DATA_W-1:0] d, logic l);
    set_result_t e;
    if (answer_q.size() == 0) begin
      report_mismatch("result word with none pending", '0, d);
      return;
    end
    e = answer_q.pop_front();
    if (d[31:0] !== e.elem)
      report_mismatch("result_element", 40'(e.elem), 40'(d[31:0]));
    if (d[RES_VALID_BIT] !== e.valid)
      report_mismatch("result_valid", 40'(e.valid), 40'(d[RES_VALID_BIT]));
    if (d[RES_ASB_BIT] !== e.asb)
      report_mismatch("a_subset_of_b", 40'(e.asb), 40'(d[RES_ASB_BIT]));
    if (d[RES_BSA_BIT] !== e.bsa)
      report_mismatch("b_subset_of_a", 40'(e.bsa), 40'(d[RES_BSA_BIT]));
    if (d[RES_EQ_BIT] !== e.eq)
      report_mismatch("sets_equal", 40'(e.eq), 40'(d[RES_EQ_BIT]));
    if (d[RES_OVF_BIT] !== e.ovf)
      report_mismatch("overflow", 40'(e.ovf), 40'(d[RES_OVF_BIT]));
    if (l !== e.last)
      report_mismatch("last_result", 40'(e.last), 40'(l));
  endtask

  // Monitor: everything is sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      wd_cycles++;
      if (m_tvalid && m_tready) begin
        check_result(m_tdata, m_tlast);
        wd_cycles = 0;
      end
      if (s_tvalid && s_tready) begin
        track_set_item(s_tuser[0], s_tdata[31:0], s_tdata[HAS_ELEM_BIT], s_tlast);
        s_acc = 1'b1;
        items_left--;
        wd_cycles = 0;
      end
      if (cfg_valid && cfg_ready) begin
        mode_m = cfg_data;
        wd_cycles = 0;
      end
      if (wd_cycles >= WD_LIMIT) begin
        $display("set_algebra_engine test failed");
        $finish;
      end
    end
  end

  // Input driver: a word stays up until it is taken, then an optional gap.
  always @(negedge clk) begin
    set_item_t itm;
    logic [IN_DATA_W-1:0] w;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_acc = 1'b0;
    end else if (!s_tvalid || s_acc) begin
      s_acc = 1'b0;
      if (s_gap > 0) begin
        s_tvalid <= 1'b0;
        s_gap--;
      end else if (pending_items.size() > 0) begin
        itm = pending_items.pop_front();
        w = '0;
        w[31:0] = itm.elem;
        w[HAS_ELEM_BIT] = itm.has;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= itm.sel;
        s_tlast  <= itm.last;
        s_gap = idle_s ? pick_gap() : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output side back-pressure.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (m_stall > 0) begin
      m_tready <= 1'b0;
      m_stall--;
    end else begin
      m_tready <= 1'b1;
      m_stall = idle_m ? pick_gap() : 0;
    end
  end

  task automatic push_item(bit sel, logic [31:0] v, bit has, bit last);
    set_item_t itm;
    itm.sel  = sel;
    itm.elem = v;
    itm.has  = has;
    itm.last = last;
    pending_items.push_back(itm);
    items_left++;
    items_pushed++;
  endtask

  // Let every word in flight drain, then give the block time to settle.
  task automatic wait_idle();
    do @(negedge clk); while (items_left != 0 || answer_q.size() != 0);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(bit narrow);
    int r;
    if (narrow) return 32'($urandom_range(0, 15)) - 32'd8;
    r = $urandom_range(0, 7);
    if (r == 0) return 32'h8000_0000;
    if (r == 1) return 32'h7fff_ffff;
    return $urandom;
  endfunction

  task automatic push_noise(bit sel);
    push_item(sel, $urandom, 1'($urandom), 1'($urandom));
  endtask

  // One run with random content; B reuses A values often so the answers overlap.
  task automatic push_random_run(int na, int nb, bit narrow);
    logic [31:0] pool[$];
    logic [31:0] v;
    for (int i = 0; i < na; i++) begin
      if ($urandom_range(0, 9) == 0) push_noise(1'b1);
      v = pick_value(narrow);
      pool.push_back(v);
      push_item(1'b0, v, $urandom_range(0, 9) != 0, i == na - 1);
    end
    if (na == 0) push_item(1'b0, $urandom, 1'b0, 1'b1);
    for (int i = 0; i < nb; i++) begin
      if ($urandom_range(0, 9) == 0) push_noise(1'b0);
      if (pool.size() > 0 && $urandom_range(0, 1) == 1)
        v = pool[$urandom_range(0, pool.size() - 1)];
      else
        v = pick_value(narrow);
      push_item(1'b1, v, $urandom_range(0, 9) != 0, i == nb - 1);
    end
    if (nb == 0) push_item(1'b1, $urandom, 1'b0, 1'b1);
  endtask

  // Both stores overflow; a duplicate arrives while A is full.
  task automatic push_full_run();
    logic [31:0] a_vals[$];
    logic [31:0] v;
    for (int i = 0; i < 34; i++) begin
      v = {8'(i), 24'($urandom)};
      a_vals.push_back(v);
      push_item(1'b0, v, 1'b1, 1'b0);
    end
    push_item(1'b0, a_vals[0], 1'b1, 1'b0);
    push_item(1'b0, a_vals[1], 1'b0, 1'b1);
    for (int i = 0; i < 33; i++) begin
      v = (i % 2 == 0) ? a_vals[i] : {8'(i + 64), 24'($urandom)};
      push_item(1'b1, v, 1'b1, i == 32);
    end
  endtask

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return MODE_UNION;
    if (r < 6) return MODE_INTER;
    if (r < 9) return MODE_DIFF;
    return MODE_UNUSED;
  endfunction

  initial begin
    int start_count;
    int round;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, duplicates, ignored wrong-set words, union with new B values.
    push_item(1'b0, 32'h8000_0000, 1'b1, 1'b0);
    push_item(1'b1, 32'h1234_5678, 1'b1, 1'b1);
    push_item(1'b0, 32'h7fff_ffff, 1'b1, 1'b0);
    push_item(1'b0, 32'h0000_0000, 1'b1, 1'b0);
    push_item(1'b0, 32'h7fff_ffff, 1'b1, 1'b0);
    push_item(1'b0, 32'hffff_ffff, 1'b0, 1'b1);
    push_item(1'b1, 32'h0000_0000, 1'b1, 1'b0);
    push_item(1'b0, 32'h0000_0005, 1'b1, 1'b1);
    push_item(1'b1, 32'h0000_0005, 1'b1, 1'b0);
    push_item(1'b1, 32'h8000_0000, 1'b1, 1'b0);
    push_item(1'b1, 32'h0000_0007, 1'b1, 1'b1);
    // Two empty sets give an empty answer with the subset and equality flags set.
    push_item(1'b0, 32'hdead_beef, 1'b0, 1'b1);
    push_item(1'b1, 32'hdead_beef, 1'b0, 1'b1);
    wait_idle();
    write_mode(MODE_INTER);
    push_item(1'b0, 32'd1, 1'b1, 1'b0);
    push_item(1'b0, 32'd2, 1'b1, 1'b1);
    push_item(1'b1, 32'd2, 1'b1, 1'b0);
    push_item(1'b1, 32'd1, 1'b1, 1'b0);
    push_item(1'b1, 32'd3, 1'b1, 1'b1);
    wait_idle();
    write_mode(MODE_DIFF);
    push_item(1'b0, 32'd4, 1'b1, 1'b1);
    push_item(1'b1, 32'd4, 1'b1, 1'b1);
    wait_idle();
    write_mode(MODE_UNUSED);
    push_item(1'b0, 32'd9, 1'b1, 1'b1);
    push_item(1'b1, 32'd0, 1'b0, 1'b1);

    start_count = items_pushed;
    round = 0;
    while (items_pushed - start_count < RAND_ITEMS) begin
      wait_idle();
      write_mode(round == 0 ? MODE_UNION : pick_mode());
      idle_s = $urandom_range(0, 3) != 0;
      idle_m = $urandom_range(0, 3) != 0;
      if (round == 2) push_full_run();
      repeat ($urandom_range(1, 3))
        push_random_run($urandom_range(0, 6), $urandom_range(0, 6), 1'($urandom));
      round++;
    end

    wait_idle();
    if (errors == 0) begin
      $display("set_algebra_engine test passed");
    end else begin
      $display("set_algebra_engine test failed");
    end
    $finish;
  end

endmodule
